// ===== rtl/ter_pkg.sv =====
package ter_pkg;

    localparam int NUM_STATES  = 16;
    localparam int NUM_ACTIONS = 4;
    localparam int STATE_W     = 4;
    localparam int ACTION_W    = 2;
    localparam int PAIRS       = NUM_STATES * NUM_ACTIONS;
    localparam int TRIPLES     = PAIRS * NUM_STATES;
    localparam int PAIR_W      = $clog2(PAIRS);
    localparam int TRIPLE_W    = $clog2(TRIPLES);
    localparam int CLR_W       = TRIPLE_W + 1;
    localparam int DIV_W       = 33;
    localparam int DIVCNT_W    = 6;

    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
    localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
    localparam logic [62:0] MAX63 = 63'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic load;
        logic rd_start;
        logic calc_delta;
        logic div_start;
        logic div_step;
        logic mean_done;
        logic mul_step;
        logic write_back;
        logic emit;
        logic emit_bad;
    } ter_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic bad_index;
        logic div_done;
    } ter_status_t;

endpackage

// ===== rtl/ter_datapath.sv =====
module ter_datapath
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  ter_pkg::ter_cmd_t         cmd,
    output ter_pkg::ter_status_t      status,
    input  logic [3:0]                from_state,
    input  logic [1:0]                action_taken,
    input  logic [3:0]                to_state,
    input  logic signed [31:0]        reward,
    output logic                      done,
    output logic [31:0]               transition_count,
    output logic [31:0]               pair_count,
    output logic signed [31:0]        mean_reward,
    output logic [62:0]               squared_diff_sum,
    output logic [47:0]               step_count
);
    import ter_pkg::*;

    logic [31:0] tcnt_mem [TRIPLES];
    logic [31:0] pcnt_mem [PAIRS];
    logic [31:0] mean_mem [PAIRS];
    logic [62:0] sum_mem  [PAIRS];

    logic [CLR_W-1:0]   clr_reg;
    logic [STATE_W-1:0] s_reg, s1_reg;
    logic [ACTION_W-1:0] a_reg;
    logic signed [31:0] r_reg;
    logic               bad_reg;
    logic [31:0]        tcnt_reg, pcnt_reg;
    logic signed [31:0] mean_reg;
    logic [62:0]        sum_reg;
    logic [47:0]        steps_reg;
    logic signed [32:0] delta_reg;
    logic [31:0]        dmag_reg;
    logic               dneg_reg;
    logic [31:0]        quo_reg;
    logic [32:0]        rem_reg;
    logic [DIVCNT_W-1:0] dcnt_reg;
    logic signed [31:0] nmean_reg;
    logic [63:0]        prod_reg;
    logic               done_reg;

    logic [PAIR_W-1:0]   pidx;
    logic [TRIPLE_W-1:0] tidx;
    logic [31:0] tcnt_inc, pcnt_inc;
    logic [32:0] rem_sh, rem_sub;
    logic signed [32:0] q_signed, nm_full, rest_full;
    logic [64:0] sum_add;

    assign pidx = {s_reg, a_reg};
    assign tidx = {s_reg, a_reg, s1_reg};
    assign tcnt_inc = (tcnt_reg == MAX32) ? tcnt_reg : tcnt_reg + 32'd1;
    assign pcnt_inc = (pcnt_reg == MAX32) ? pcnt_reg : pcnt_reg + 32'd1;
    assign rem_sh  = {rem_reg[31:0], dmag_reg[31]};
    assign rem_sub = rem_sh - {1'b0, pcnt_reg};
    assign q_signed = dneg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    assign nm_full  = $signed({mean_reg[31], mean_reg}) + q_signed;
    assign rest_full = $signed({r_reg[31], r_reg}) - $signed({nmean_reg[31], nmean_reg});
    assign sum_add = {2'b00, sum_reg} + {1'b0, prod_reg};

    assign status.clear_done = (clr_reg == CLR_W'(TRIPLES));
    assign status.bad_index  = bad_reg;
    assign status.div_done   = (dcnt_reg == DIVCNT_W'(32));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg   <= '0;
            steps_reg <= '0;
            done_reg  <= 1'b0;
            dcnt_reg  <= '0;
        end
        else
        begin
            done_reg <= cmd.emit || cmd.emit_bad;
            if (!status.clear_done)
                clr_reg <= clr_reg + CLR_W'(1);
            if (cmd.write_back && steps_reg != MAX48)
                steps_reg <= steps_reg + 48'd1;
            if (cmd.div_start)
                dcnt_reg <= '0;
            else if (cmd.div_step)
                dcnt_reg <= dcnt_reg + DIVCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (!status.clear_done)
        begin
            tcnt_mem[clr_reg[TRIPLE_W-1:0]] <= '0;
            if (clr_reg < CLR_W'(PAIRS))
            begin
                pcnt_mem[clr_reg[PAIR_W-1:0]] <= '0;
                mean_mem[clr_reg[PAIR_W-1:0]] <= '0;
                sum_mem[clr_reg[PAIR_W-1:0]]  <= '0;
            end
        end
        if (cmd.load)
        begin
            s_reg   <= from_state;
            a_reg   <= action_taken;
            s1_reg  <= to_state;
            r_reg   <= reward;
            bad_reg <= (32'(from_state) >= NUM_STATES) || (32'(action_taken) >= NUM_ACTIONS)
                       || (32'(to_state) >= NUM_STATES);
        end
        if (cmd.rd_start)
        begin
            tcnt_reg <= tcnt_mem[tidx];
            pcnt_reg <= pcnt_mem[pidx];
            mean_reg <= mean_mem[pidx];
            sum_reg  <= sum_mem[pidx];
        end
        if (cmd.calc_delta)
        begin
            tcnt_reg  <= tcnt_inc;
            pcnt_reg  <= pcnt_inc;
            delta_reg <= $signed({r_reg[31], r_reg}) - $signed({mean_reg[31], mean_reg});
        end
        if (cmd.div_start)
        begin
            dneg_reg <= delta_reg[32];
            dmag_reg <= delta_reg[32] ? 32'(-delta_reg) : delta_reg[31:0];
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            dmag_reg <= {dmag_reg[30:0], 1'b0};
            if (!rem_sub[32])
            begin
                rem_reg <= rem_sub;
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
        if (cmd.mean_done)
        begin
            nmean_reg <= nm_full[31:0];
            dmag_reg  <= delta_reg[32] ? 32'(-delta_reg) : delta_reg[31:0];
        end
        if (cmd.mul_step)
        begin
            prod_reg <= 64'(dmag_reg) * 64'(rest_full[32] ? 32'(-rest_full) : rest_full[31:0]);
        end
        if (cmd.write_back)
        begin
            sum_reg <= (sum_add > {2'b00, MAX63}) ? MAX63 : sum_add[62:0];
            tcnt_mem[tidx] <= tcnt_reg;
            pcnt_mem[pidx] <= pcnt_reg;
            mean_mem[pidx] <= nmean_reg;
            sum_mem[pidx]  <= (sum_add > {2'b00, MAX63}) ? MAX63 : sum_add[62:0];
        end
        if (cmd.emit_bad)
        begin
            tcnt_reg  <= '0;
            pcnt_reg  <= '0;
            nmean_reg <= '0;
            sum_reg   <= '0;
        end
    end

    assign done             = done_reg;
    assign transition_count = tcnt_reg;
    assign pair_count       = pcnt_reg;
    assign mean_reward      = nmean_reg;
    assign squared_diff_sum = sum_reg;
    assign step_count       = steps_reg;

endmodule

// ===== rtl/ter_ctrl.sv =====
module ter_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  ter_pkg::ter_status_t status,
    output ter_pkg::ter_cmd_t    cmd
);
    import ter_pkg::*;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_CHECK = 4'd2;
    localparam logic [3:0] ST_READ  = 4'd3;
    localparam logic [3:0] ST_DELTA = 4'd4;
    localparam logic [3:0] ST_DIV   = 4'd6;
    localparam logic [3:0] ST_MEAN  = 4'd7;
    localparam logic [3:0] ST_MUL   = 4'd8;
    localparam logic [3:0] ST_WB    = 4'd9;
    localparam logic [3:0] ST_WAIT  = 4'd11;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_done)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.bad_index)
                begin
                    cmd.emit_bad = 1'b1;
                    state_next = ST_WAIT;
                end
                else
                begin
                    cmd.rd_start = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.calc_delta = 1'b1;
                state_next = ST_DELTA;
            end
            ST_DELTA:
            begin
                cmd.div_start = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.mean_done = 1'b1;
                    state_next = ST_MEAN;
                end
                else
                    cmd.div_step = 1'b1;
            end
            ST_MEAN:
            begin
                cmd.mul_step = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.write_back = 1'b1;
                state_next = ST_WB;
            end
            ST_WB:
            begin
                cmd.emit = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/transition_experience_recorder_top.sv =====
// channel  | handshake           | fields
// ---------+---------------------+---------------------------------------------
// input    | start & !busy       | from_state, action_taken, to_state, reward
// result   | done (one cycle)    | transition_count, pair_count, mean_reward,
//          |                     | squared_diff_sum, step_count
//
// a valid transaction passes check, read, delta, the 32-step restoring divide
// of the delta by the pair count, mean, multiply and write-back before done;
// the next can be accepted in the cycle after done
// an out-of-range index skips the table access and shows done after the check
// after reset a clearing pass over the tables holds busy high
// done marks the result for one cycle, cannot be stalled; outputs then hold it
module transition_experience_recorder_top
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [3:0]         from_state,
    input  logic [1:0]         action_taken,
    input  logic [3:0]         to_state,
    input  logic signed [31:0] reward,
    output logic               done,
    output logic [31:0]        transition_count,
    output logic [31:0]        pair_count,
    output logic signed [31:0] mean_reward,
    output logic [62:0]        squared_diff_sum,
    output logic [47:0]        step_count
);
    import ter_pkg::*;

    ter_cmd_t    cmd;
    ter_status_t status;

    ter_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    ter_datapath u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .from_state       (from_state),
        .action_taken     (action_taken),
        .to_state         (to_state),
        .reward           (reward),
        .done             (done),
        .transition_count (transition_count),
        .pair_count       (pair_count),
        .mean_reward      (mean_reward),
        .squared_diff_sum (squared_diff_sum),
        .step_count       (step_count)
    );

endmodule
